[rtl/core/dmm_pkg.sv]
// Shared types and constants for the dense matrix multiply block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dmm_pkg;
    localparam int DIM_W = 4;
    localparam int SUM_W = 40;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    // control handed to the cell chain
    typedef struct packed {
        logic start;
        logic feed;
    } cell_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        r = v;
        if (r == '0)
            r = DIM_W'(1);
        if (r > mx)
            r = mx;
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/core/dmm_cell.sv]
// One multiply-accumulate cell of the product chain.
// Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmm_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire dmm_pkg::cell_ctl_t       ctl,
    input  wire signed [DATA_WIDTH-1:0]   a_in,
    input  wire signed [DATA_WIDTH-1:0]   b_in,
    input  wire signed [dmm_pkg::SUM_W-1:0] sum_in,
    input  wire                           shift,
    output logic signed [dmm_pkg::SUM_W-1:0] sum_out
);
    import dmm_pkg::*;

    logic signed [2*DATA_WIDTH-1:0] prod_reg;
    logic                           pv_reg;
    logic signed [SUM_W-1:0]        acc_reg;
    logic signed [SUM_W-1:0]        acc_next;

    // product registered before accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= ctl.feed;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_in * b_in;
    end

    // start wins over shift: the last drain of a row also opens the next row
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.start)
            acc_next = '0;
        else if (shift)
            acc_next = sum_in;
        else if (pv_reg)
            acc_next = acc_reg + SUM_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign sum_out = acc_reg;
endmodule
`default_nettype wire

[rtl/core/dmm_seq.sv]
// Sequencer: walks k for one product row, feeds the chain, drains results.
// Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmm_seq (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         go,
    input  wire [dmm_pkg::DIM_W-1:0]    nr,
    input  wire [dmm_pkg::DIM_W-1:0]    nk,
    input  wire [dmm_pkg::DIM_W-1:0]    nc,
    input  wire                         out_free,
    output dmm_pkg::cell_ctl_t          ctl,
    output logic [dmm_pkg::DIM_W-1:0]   r_idx,
    output logic [dmm_pkg::DIM_W-1:0]   k_idx,
    output logic                        shift,
    output logic                        emit,
    output logic [dmm_pkg::DIM_W-1:0]   c_idx,
    output logic                        emit_last,
    output logic                        busy
);
    import dmm_pkg::*;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] r_reg, r_next, k_reg, k_next, c_reg, c_next;
    logic [1:0]       wait_reg, wait_next;
    logic             start_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            wait_reg  <= wait_next;
        end
    end

    // FETCH: one k per cycle, then wait for memory read, product and accumulate before DRAIN
    always_comb
    begin
        state_next = state_reg;
        r_next = r_reg;
        k_next = k_reg;
        c_next = c_reg;
        wait_next = wait_reg;
        start_c = 1'b0;
        shift = 1'b0;
        emit = 1'b0;
        emit_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_FETCH;
                    r_next = '0;
                    k_next = '0;
                    start_c = 1'b1;
                end
            end
            ST_FETCH:
            begin
                if (k_reg == nk)
                begin
                    if (wait_reg == 2'd2)
                    begin
                        state_next = ST_DRAIN;
                        c_next = '0;
                        wait_next = '0;
                    end
                    else
                        wait_next = wait_reg + 2'd1;
                end
                else
                    k_next = k_reg + DIM_W'(1);
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    shift = 1'b1;
                    emit_last = (r_reg + DIM_W'(1) == nr) && (c_reg + DIM_W'(1) == nc);
                    if (c_reg + DIM_W'(1) == nc)
                    begin
                        if (r_reg + DIM_W'(1) == nr)
                            state_next = ST_IDLE;
                        else
                        begin
                            state_next = ST_FETCH;
                            r_next = r_reg + DIM_W'(1);
                            k_next = '0;
                            start_c = 1'b1;
                        end
                    end
                    else
                        c_next = c_reg + DIM_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory read issued this cycle; feed flag lines up with read data
    logic rd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_reg <= 1'b0;
        else
            rd_reg <= (state_reg == ST_FETCH) && (k_reg != nk);
    end
    assign ctl = cell_ctl_t'{start: start_c, feed: rd_reg};

    assign r_idx = r_reg;
    assign k_idx = k_reg;
    assign c_idx = c_reg;
    assign busy  = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> k_reg <= nk) else $error("k beyond inner size");
    a_emit_drain: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> state_reg == ST_DRAIN) else $error("emit outside drain");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_last |=> state_reg == ST_IDLE) else $error("last without end");
`endif
endmodule
`default_nettype wire

[rtl/core/dense_matrix_multiply.sv]
// Dense matrix multiply top level: APB registers, A/B stores, cell chain.
// Depends on dmm_pkg, dmm_seq, dmm_cell.
// Load transactions (op 0/1) are accepted back to back.
// Compute holds the input (in_ready low) until the last result is drained: per row,
// the inner_len k walk and the pipeline flush, then cols_b drain results (1/cycle unstalled).
// Reset clears control and registers (dims to 8); stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dense_matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  op,
    input  wire  [5:0]  index,
    input  wire  signed [15:0] value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  row,
    output logic [2:0]  col,
    output logic signed [39:0] dot_sum,
    output logic        last
);
    import dmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NB    = 8;                       // B banks, picked by low index bits
    localparam int BW    = (DEPTH + NB - 1) / NB;   // words per B bank
    localparam int WAW   = (BW > 1) ? $clog2(BW) : 1;

    // ---------------- configuration registers
    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic             wr_en;
    reg_idx_t         waddr;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign waddr  = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(8);
            inner_reg <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
        end
        else if (wr_en)
        begin
            case (waddr)
                REG_ROWS_A:    rows_reg  <= pwdata[DIM_W-1:0];
                REG_INNER_LEN: inner_reg <= pwdata[DIM_W-1:0];
                REG_COLS_B:    cols_reg  <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (waddr)
            REG_ROWS_A:    prdata = 32'(rows_reg);
            REG_INNER_LEN: prdata = 32'(inner_reg);
            REG_COLS_B:    prdata = 32'(cols_reg);
            default:       prdata = '0;
        endcase
    end

    logic [DIM_W-1:0] nr, nk, nc;
    assign nr = clamp_dim(rows_reg, DIM_W'(MAX_DIM));
    assign nk = clamp_dim(inner_reg, DIM_W'(MAX_DIM));
    assign nc = clamp_dim(cols_reg, DIM_W'(MAX_DIM));

    // ---------------- sequencer
    cell_ctl_t        ctl;
    logic [DIM_W-1:0] r_idx, k_idx, c_idx;
    logic             shift, emit, emit_last, busy, out_free, go, in_acc;
    op_t              op_in;

    assign op_in    = op_t'(op);
    assign in_ready = !busy;
    assign in_acc   = in_valid && in_ready;
    assign go       = in_acc && (op_in == OP_COMPUTE);
    assign out_free = !out_valid || out_ready;

    dmm_seq u_seq (
        .clk(clk), .rst_n(rst_n), .go(go), .nr(nr), .nk(nk), .nc(nc),
        .out_free(out_free), .ctl(ctl), .r_idx(r_idx), .k_idx(k_idx),
        .shift(shift), .emit(emit), .c_idx(c_idx), .emit_last(emit_last),
        .busy(busy)
    );

    // ---------------- stores: A one word/cycle, B one k-row/cycle
    // B keeps the flat row-major index, banked by its low 3 bits. A k-row
    // k*nc .. k*nc+nc-1 is at most 8 consecutive entries, so each bank
    // gives one word and a rotate lines the banks up with the cells.
    logic [DATA_WIDTH-1:0] mem_a [DEPTH];
    logic [DATA_WIDTH-1:0] mem_b [NB][2**WAW];
    logic signed [DATA_WIDTH-1:0] a_rd_reg;
    logic signed [DATA_WIDTH-1:0] b_rd_reg [NB];
    logic signed [DATA_WIDTH-1:0] b_cell [MAX_DIM];
    logic [2:0]      rot_reg;
    logic [AW-1:0]   a_addr;
    logic [7:0]      b_base;
    logic [2:0]      b_off [NB];
    logic [WAW-1:0]  b_word [NB];
    logic            idx_ok;

    assign idx_ok = (7'(index) < 7'(DEPTH));
    assign a_addr = AW'(8'(r_idx) * 8'(nk) + 8'(k_idx));
    assign b_base = 8'(k_idx) * 8'(nc);

    // word read from each bank: the entry of the k-row that falls in it
    always_comb
    begin
        for (int j = 0; j < NB; j++)
        begin
            b_off[j]  = 3'(j) - b_base[2:0];
            b_word[j] = WAW'((b_base + 8'(b_off[j])) >> 3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && op_in == OP_WRITE_A && idx_ok)
            mem_a[AW'(index)] <= DATA_WIDTH'(value);
        if (in_acc && op_in == OP_WRITE_B && idx_ok)
            mem_b[index[2:0]][WAW'(index >> 3)] <= DATA_WIDTH'(value);
        a_rd_reg <= mem_a[a_addr];
        for (int j = 0; j < NB; j++)
            b_rd_reg[j] <= mem_b[j][b_word[j]];
        rot_reg <= b_base[2:0];
    end

    // column c of the k-row sits in bank (k*nc + c) mod 8
    always_comb
    begin
        for (int c = 0; c < MAX_DIM; c++)
            b_cell[c] = b_rd_reg[rot_reg + 3'(c)];
    end

    // ---------------- cell chain: each cell accumulates one column
    logic signed [SUM_W-1:0] sums [MAX_DIM+1];
    assign sums[MAX_DIM] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++)
        begin : g_cell
            dmm_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl),
                .a_in(a_rd_reg), .b_in(b_cell[g]),
                .sum_in(sums[g+1]), .shift(shift), .sum_out(sums[g])
            );
        end
    endgenerate

    // ---------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (emit)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row     <= r_idx[2:0];
            col     <= c_idx[2:0];
            dot_sum <= sums[0];
            last    <= emit_last;
        end
    end

`ifndef SYNTHESIS
    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("input taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free) else $error("result overwritten");
`endif
endmodule
`default_nettype wire
